@@ src/ems_pkg.sv @@
// Shared types, constants and helpers for the enumerative syndrome decoder.
package ems_pkg;

  localparam int unsigned DefNumBits      = 32;
  localparam int unsigned DefNumChecks    = 16;
  localparam int unsigned DefNumLogical   = 4;
  localparam int unsigned DefMaxWeight    = 4;

  localparam int unsigned ScoreW  = 40;
  localparam int unsigned FactorW = 16;
  localparam int unsigned ProdW   = 17;
  localparam logic [ProdW-1:0] Q16One = 17'h10000;
  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  // Command codes of an input beat.
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdDecode = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegBitsInUse    = 2'd0;
  localparam logic [1:0] RegChecksInUse  = 2'd1;
  localparam logic [1:0] RegLogicalInUse = 2'd2;
  localparam logic [1:0] RegMaxWeight    = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VISIT,
    ST_ACCUM,
    ST_NEXT,
    ST_UP,
    ST_LOAD,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [5:0] bits_in_use;
    logic [4:0] checks_in_use;
    logic [2:0] logical_in_use;
    logic [2:0] weight_limit;
  } cfg_t;

  // Commands to the class accumulator memory.
  typedef struct packed {
    logic             clear;
    logic             rd;
    logic             add;
    logic [7:0]       addr;
    logic [ProdW-1:0] value;
  } acc_ctl_t;

  typedef struct packed {
    logic [7:0]        cls;
    logic              found;
    logic [ScoreW-1:0] score;
  } result_t;

  // Reverse the low len bits of k: logical row 0 becomes the most significant.
  function automatic logic [7:0] rev_class(input logic [7:0] k, input logic [3:0] len);
    logic [7:0] r;
    int         idx;
    r = '0;
    for (int b = 0; b < 8; b++) begin
      idx = int'(len) - 1 - b;
      if ((b < int'(len)) && k[b]) begin
        r[idx[2:0]] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

@@ src/ems_store.sv @@
// Column and factor memory, one write port and one registered read port.
module ems_store import ems_pkg::*; #(
  parameter int unsigned NUM_BITS    = DefNumBits,
  parameter int unsigned NUM_CHECKS  = DefNumChecks,
  parameter int unsigned NUM_LOGICAL = DefNumLogical
) (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [$clog2(NUM_BITS)-1:0]         wr_addr,
  input  logic [NUM_CHECKS+NUM_LOGICAL-1:0]   wr_column,
  input  logic [FactorW-1:0]                  wr_factor,
  input  logic [$clog2(NUM_BITS)-1:0]         rd_addr,
  output logic [NUM_CHECKS+NUM_LOGICAL-1:0]   rd_column,
  output logic [FactorW-1:0]                  rd_factor
);

  localparam int unsigned EntryW = NUM_CHECKS + NUM_LOGICAL + FactorW;

  logic [EntryW-1:0] mem [NUM_BITS];

  // Write on load beats; read every cycle through a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_column, wr_factor};
    end
    {rd_column, rd_factor} <= mem[rd_addr];
  end

endmodule

@@ src/ems_accum.sv @@
// Class likelihood memory with seen flags and a saturating add on write-back.
module ems_accum import ems_pkg::*; #(
  parameter int unsigned NUM_LOGICAL = DefNumLogical
) (
  input  logic              clk,
  input  logic              rst,
  input  acc_ctl_t          ctl,
  output logic              rd_seen,
  output logic [ScoreW-1:0] rd_score
);

  localparam int unsigned ClassN = 1 << NUM_LOGICAL;

  logic [ScoreW-1:0]      mem [ClassN];
  logic [ClassN-1:0]      seen;
  logic [ScoreW-1:0]      rdata;
  logic                   rseen;
  logic [NUM_LOGICAL-1:0] addr;
  logic [ScoreW:0]        sum;

  assign addr = ctl.addr[NUM_LOGICAL-1:0];

  // An entry not seen since the last clear reads as zero.
  assign rd_seen  = rseen;
  assign rd_score = rseen ? rdata : '0;

  assign sum = {1'b0, rd_score} + (ScoreW+1)'(ctl.value);

  // Read-modify-write: a read is always issued the cycle before its add.
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata <= mem[addr];
    end
    if (ctl.add) begin
      mem[addr] <= sum[ScoreW] ? ScoreMax : sum[ScoreW-1:0];
    end
  end

  // Seen flags clear at reset and at the start of every decode.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      rseen <= 1'b0;
    end else begin
      if (ctl.rd) begin
        rseen <= seen[addr];
      end
      if (ctl.clear) begin
        seen <= '0;
      end else if (ctl.add) begin
        seen[addr] <= 1'b1;
      end
    end
  end

endmodule

@@ src/ems_enum.sv @@
// Pattern enumeration sequencer: depth-first walk, accumulation and final scan.
module ems_enum import ems_pkg::*; #(
  parameter int unsigned NUM_BITS         = DefNumBits,
  parameter int unsigned NUM_CHECKS       = DefNumChecks,
  parameter int unsigned NUM_LOGICAL      = DefNumLogical,
  parameter int unsigned MAX_WEIGHT_BOUND = DefMaxWeight
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic                              start,
  input  logic [NUM_CHECKS-1:0]             syndrome,
  output logic [$clog2(NUM_BITS)-1:0]       store_addr,
  input  logic [NUM_CHECKS+NUM_LOGICAL-1:0] store_column,
  input  logic [FactorW-1:0]                store_factor,
  output acc_ctl_t                          acc_ctl,
  input  logic                              acc_seen,
  input  logic [ScoreW-1:0]                 acc_score,
  output logic                              busy,
  output logic                              done,
  input  logic                              done_ack,
  output result_t                           result
);

  localparam int unsigned IW = $clog2(NUM_BITS);
  localparam int unsigned NW = $clog2(NUM_BITS + 1);
  localparam int unsigned DW = $clog2(MAX_WEIGHT_BOUND + 1);
  localparam int unsigned CW = NUM_CHECKS;
  localparam int unsigned LW = NUM_LOGICAL;
  localparam int unsigned AW = CW + LW;

  state_t state, state_next;

  logic [IW-1:0]    pos      [MAX_WEIGHT_BOUND+1];
  logic [AW-1:0]    acc_stk  [MAX_WEIGHT_BOUND+1];
  logic [ProdW-1:0] prod_stk [MAX_WEIGHT_BOUND+1];
  logic [DW-1:0]    d;
  logic [CW-1:0]    target;
  logic [LW:0]      scan_k;
  logic [7:0]       scan_cls;
  logic             found;
  logic [7:0]       best_cls;
  logic [ScoreW-1:0] win_score;

  logic [NW-1:0]    n_eff;
  logic [DW-1:0]    w_eff;
  logic [3:0]       l_eff;
  logic [CW-1:0]    chk_mask;
  logic [LW-1:0]    log_mask;
  logic [DW-1:0]    dm1;
  logic [NW-1:0]    child_start;
  logic [NW-1:0]    sibling;
  logic             match;
  logic [LW-1:0]    cls;
  logic [ProdW+FactorW-1:0] mult;
  logic [7:0]       bits8;
  logic [3:0]       weight4;
  logic [3:0]       logical4;

  // Register values clamped to the built sizes, and row masks.
  always_comb begin
    bits8    = {2'b00, cfg.bits_in_use};
    weight4  = {1'b0, cfg.weight_limit};
    logical4 = {1'b0, cfg.logical_in_use};
    n_eff = (bits8 > 8'(NUM_BITS)) ? NW'(NUM_BITS) : NW'(bits8);
    w_eff = (weight4 > 4'(MAX_WEIGHT_BOUND)) ? DW'(MAX_WEIGHT_BOUND) : DW'(weight4);
    l_eff = (logical4 > 4'(NUM_LOGICAL)) ? 4'(NUM_LOGICAL) : logical4;
    for (int i = 0; i < CW; i++) begin
      chk_mask[i] = (i < int'(cfg.checks_in_use));
    end
    for (int i = 0; i < LW; i++) begin
      log_mask[i] = (i < int'(cfg.logical_in_use));
    end
  end

  // Current node: match test, class and the candidate next positions.
  always_comb begin
    dm1         = (d == '0) ? '0 : d - 1'b1;
    child_start = (d == '0) ? '0 : NW'(pos[dm1]) + 1'b1;
    sibling     = NW'(pos[dm1]) + 1'b1;
    match       = ((acc_stk[d][CW-1:0] ^ target) & chk_mask) == '0;
    cls         = acc_stk[d][CW +: LW] & log_mask;
    mult        = prod_stk[dm1] * store_factor;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory commands.
  always_comb begin
    state_next    = state;
    store_addr    = '0;
    acc_ctl       = '0;
    done          = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          acc_ctl.clear = 1'b1;
          state_next    = ST_VISIT;
        end
      end
      ST_VISIT: begin
        if (match) begin
          acc_ctl.rd   = 1'b1;
          acc_ctl.addr = 8'(cls);
          state_next   = ST_ACCUM;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_ACCUM: begin
        acc_ctl.add   = 1'b1;
        acc_ctl.addr  = 8'(cls);
        acc_ctl.value = prod_stk[d];
        state_next    = ST_NEXT;
      end
      ST_NEXT: begin
        if ((d < w_eff) && (child_start < n_eff)) begin
          store_addr = child_start[IW-1:0];
          state_next = ST_LOAD;
        end else begin
          state_next = ST_UP;
        end
      end
      ST_UP: begin
        if (d == '0) begin
          state_next = ST_SCAN_RD;
        end else if (sibling < n_eff) begin
          store_addr = sibling[IW-1:0];
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_VISIT;
      end
      ST_SCAN_RD: begin
        acc_ctl.rd   = 1'b1;
        acc_ctl.addr = rev_class(8'(scan_k[LW-1:0]), l_eff);
        state_next   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (9'(scan_k) + 9'd1 == (9'd1 << l_eff)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        if (done_ack) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Walk state: depth, positions and the per-depth partial column and product.
  always_ff @(posedge clk) begin
    if (rst) begin
      d <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            d           <= '0;
            acc_stk[0]  <= '0;
            prod_stk[0] <= Q16One;
            target      <= syndrome & chk_mask;
          end
        end
        ST_NEXT: begin
          if ((d < w_eff) && (child_start < n_eff)) begin
            pos[d] <= child_start[IW-1:0];
            d      <= d + 1'b1;
          end
        end
        ST_UP: begin
          if (d != '0) begin
            if (sibling < n_eff) begin
              pos[dm1] <= sibling[IW-1:0];
            end else begin
              d <= dm1;
            end
          end
        end
        ST_LOAD: begin
          acc_stk[d]  <= acc_stk[dm1] ^ store_column;
          prod_stk[d] <= mult[FactorW +: ProdW];
        end
        default: ;
      endcase
    end
  end

  // Final scan over the classes in tie-break order.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_k <= '0;
      found  <= 1'b0;
    end else begin
      unique case (state)
        ST_UP: begin
          if (d == '0) begin
            scan_k    <= '0;
            found     <= 1'b0;
            best_cls  <= '0;
            win_score <= '0;
          end
        end
        ST_SCAN_RD: begin
          scan_cls <= rev_class(8'(scan_k[LW-1:0]), l_eff);
        end
        ST_SCAN_CMP: begin
          scan_k <= scan_k + 1'b1;
          if (acc_seen && (!found || (acc_score > win_score))) begin
            found     <= 1'b1;
            best_cls  <= scan_cls;
            win_score <= acc_score;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy         = (state != ST_IDLE);
  assign result.cls   = best_cls;
  assign result.found = found;
  assign result.score = win_score;

endmodule

@@ src/enumerative_ml_syndrome_decoder_top.sv @@
// Top level: configuration port, input and output beats, memory and sequencer.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   in       | in_valid, in_stall | command, column_index, column_checks,
//            |                    | column_logical, bit_factor, syndrome
//   out      | out_valid,out_stall| logical_estimate, found, class_score
//   config   | psel, penable, ... | bits_in_use, checks_in_use, logical_in_use,
//            |                    | weight_limit at byte addresses 0, 4, 8, 12
//
// A load beat writes the column memory directly. A decode goes through each
// visited pattern in order (column memory read, partial column and product,
// match test, step to the next pattern), adds an accumulator write-back for
// each matching pattern, then reads every logical class for the final scan.
// in_stall is high while a decode runs; a finished result waits in the output
// register, and a new decode may finish only once that register is free.
// Reset is synchronous and clears control state and the class seen flags.
module enumerative_ml_syndrome_decoder_top import ems_pkg::*; #(
  parameter int unsigned NUM_BITS         = DefNumBits,
  parameter int unsigned NUM_CHECKS       = DefNumChecks,
  parameter int unsigned NUM_LOGICAL      = DefNumLogical,
  parameter int unsigned MAX_WEIGHT_BOUND = DefMaxWeight
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [4:0]  column_index,
  input  logic [15:0] column_checks,
  input  logic [3:0]  column_logical,
  input  logic [15:0] bit_factor,
  input  logic [15:0] syndrome,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  logical_estimate,
  output logic        found,
  output logic [39:0] class_score
);

  localparam int unsigned IW = $clog2(NUM_BITS);
  localparam int unsigned AW = NUM_CHECKS + NUM_LOGICAL;

  cfg_t          cfg;
  logic          accept;
  logic          busy;
  logic          done;
  logic          done_ack;
  result_t       result;
  logic          store_wr;
  logic [63:0]   checks_ext;
  logic [63:0]   syn_ext;
  logic [7:0]    logical_ext;
  logic [7:0]    estimate_ext;
  logic [IW-1:0] store_addr;
  logic [AW-1:0] store_column;
  logic [FactorW-1:0] store_factor;
  acc_ctl_t      acc_ctl;
  logic          acc_seen;
  logic [ScoreW-1:0] acc_score;

  // Configuration registers.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_in_use    <= 6'd32;
      cfg.checks_in_use  <= 5'd16;
      cfg.logical_in_use <= 3'd4;
      cfg.weight_limit   <= 3'd2;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegBitsInUse:    cfg.bits_in_use    <= pwdata[5:0];
        RegChecksInUse:  cfg.checks_in_use  <= pwdata[4:0];
        RegLogicalInUse: cfg.logical_in_use <= pwdata[2:0];
        RegMaxWeight:    cfg.weight_limit   <= pwdata[2:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegBitsInUse:    prdata = {26'd0, cfg.bits_in_use};
      RegChecksInUse:  prdata = {27'd0, cfg.checks_in_use};
      RegLogicalInUse: prdata = {29'd0, cfg.logical_in_use};
      RegMaxWeight:    prdata = {29'd0, cfg.weight_limit};
    endcase
  end

  // Input beats: loads write the column memory, decodes start the sequencer.
  assign in_stall    = busy;
  assign accept      = in_valid && !in_stall;
  assign store_wr    = accept && (command == CmdLoad) && (32'(column_index) < NUM_BITS);
  assign checks_ext  = {48'd0, column_checks};
  assign syn_ext     = {48'd0, syndrome};
  assign logical_ext = {4'd0, column_logical};

  ems_store #(
    .NUM_BITS    (NUM_BITS),
    .NUM_CHECKS  (NUM_CHECKS),
    .NUM_LOGICAL (NUM_LOGICAL)
  ) u_store (
    .clk       (clk),
    .wr_en     (store_wr),
    .wr_addr   (IW'(column_index)),
    .wr_column ({logical_ext[NUM_LOGICAL-1:0], checks_ext[NUM_CHECKS-1:0]}),
    .wr_factor (bit_factor),
    .rd_addr   (store_addr),
    .rd_column (store_column),
    .rd_factor (store_factor)
  );

  ems_accum #(
    .NUM_LOGICAL (NUM_LOGICAL)
  ) u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctl      (acc_ctl),
    .rd_seen  (acc_seen),
    .rd_score (acc_score)
  );

  ems_enum #(
    .NUM_BITS         (NUM_BITS),
    .NUM_CHECKS       (NUM_CHECKS),
    .NUM_LOGICAL      (NUM_LOGICAL),
    .MAX_WEIGHT_BOUND (MAX_WEIGHT_BOUND)
  ) u_enum (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (accept && (command == CmdDecode)),
    .syndrome     (syn_ext[NUM_CHECKS-1:0]),
    .store_addr   (store_addr),
    .store_column (store_column),
    .store_factor (store_factor),
    .acc_ctl      (acc_ctl),
    .acc_seen     (acc_seen),
    .acc_score    (acc_score),
    .busy         (busy),
    .done         (done),
    .done_ack     (done_ack),
    .result       (result)
  );

  // Output register.
  assign done_ack = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && done_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && done_ack) begin
      estimate_ext <= result.cls;
      found        <= result.found;
      class_score  <= result.score;
    end
  end

  assign logical_estimate = estimate_ext[3:0];

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the enumerative maximum-likelihood syndrome decoder.
`timescale 1ns / 1ps

module testbench;
  import ems_pkg::*;

  localparam int unsigned NBits = 32;
  localparam int unsigned NChecks = 16;
  localparam int unsigned NLogical = 4;
  localparam int unsigned WBound = 4;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [4:0]  column_index;
  logic [15:0] column_checks;
  logic [3:0]  column_logical;
  logic [15:0] bit_factor;
  logic [15:0] syndrome;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  logical_estimate;
  logic        found;
  logic [39:0] class_score;

  typedef struct packed {
    logic [3:0]  est;
    logic        hit;
    logic [39:0] score;
  } decision_t;

  // Model copy of the decoder state.
  logic [19:0] col_mem [NBits];
  logic [15:0] fac_mem [NBits];
  logic [5:0]  cur_bits;
  logic [4:0]  cur_checks;
  logic [2:0]  cur_logical;
  logic [2:0]  cur_weight;
  logic [39:0] class_sum [16];
  bit          class_hit [16];
  logic [15:0] chk_sel;
  logic [3:0]  log_sel;
  logic [15:0] want_syn;
  int unsigned n_use, w_use;

  decision_t expected_decisions[$];
  int        errors;
  int        decodes_checked;

  enumerative_ml_syndrome_decoder_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Depth-first walk over all patterns, accumulating matching likelihoods.
  function automatic void walk(int unsigned start, int unsigned depth, logic [19:0] acc,
                               logic [63:0] prod);
    logic [3:0]  cls;
    logic [40:0] s;
    if ((acc[15:0] & chk_sel) == want_syn) begin
      cls = acc[19:16] & log_sel;
      s = {1'b0, class_sum[cls]} + {1'b0, prod[39:0]};
      class_sum[cls] = s[40] ? ScoreMax : s[39:0];
      class_hit[cls] = 1'b1;
    end
    if (depth >= w_use) return;
    for (int unsigned i = start; i < n_use; i++)
      walk(i + 1, depth + 1, acc ^ col_mem[i], (prod * fac_mem[i]) >> 16);
  endfunction

  function automatic decision_t predict_decision(logic [15:0] syn);
    int unsigned c, l;
    decision_t   d;
    logic [3:0]  cls;
    c = (cur_checks > NChecks) ? NChecks : cur_checks;
    l = (cur_logical > NLogical) ? NLogical : cur_logical;
    n_use = (cur_bits > NBits) ? NBits : cur_bits;
    w_use = (cur_weight > WBound) ? WBound : cur_weight;
    chk_sel = 16'((32'd1 << c) - 1);
    log_sel = 4'((32'd1 << l) - 1);
    want_syn = syn & chk_sel;
    for (int k = 0; k < 16; k++) begin
      class_sum[k] = '0;
      class_hit[k] = 1'b0;
    end
    walk(0, 0, '0, 64'h10000);
    d = '0;
    for (int unsigned k = 0; k < (32'd1 << l); k++) begin
      cls = '0;
      for (int unsigned b = 0; b < l; b++)
        if (k[b]) cls[l - 1 - b] = 1'b1;
      if (class_hit[cls] && (!d.hit || class_sum[cls] > d.score)) begin
        d.hit = 1'b1;
        d.est = cls;
        d.score = class_sum[cls];
      end
    end
    return d;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Random stall on the result side, with stretches of none.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 9) < 3) out_stall <= 1'b0;
      else out_stall <= (gap_len() > 1);
    end
  end

  // Result checker.
  initial begin
    decision_t e;
    errors = 0;
    decodes_checked = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_decisions.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          e = expected_decisions.pop_front();
          decodes_checked++;
          if (logical_estimate !== e.est) begin
            $error("logical_estimate expected %0h got %0h", e.est, logical_estimate);
            errors++;
          end
          if (found !== e.hit) begin
            $error("found expected %0b got %0b", e.hit, found);
            errors++;
          end
          if (class_score !== e.score) begin
            $error("class_score expected %0h got %0h", e.score, class_score);
            errors++;
          end
        end
      end
    end
  end

  // Valid stays high after an accepted beat until the next gap or an idle phase.
  task automatic send_beat(logic cmd, logic [4:0] idx, logic [15:0] chk, logic [3:0] lg,
                           logic [15:0] fac, logic [15:0] syn);
    int unsigned n;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    command <= cmd;
    column_index <= idx;
    column_checks <= chk;
    column_logical <= lg;
    bit_factor <= fac;
    syndrome <= syn;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CmdLoad) begin
      col_mem[idx] = {lg, chk};
      fac_mem[idx] = fac;
    end else begin
      expected_decisions = {expected_decisions, predict_decision(syn)};
    end
  endtask

  task automatic load_col(int idx);
    send_beat(CmdLoad, 5'(idx), 16'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic decode(logic [15:0] syn);
    send_beat(CmdDecode, 5'($urandom), 16'($urandom), 4'($urandom), 16'($urandom), syn);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      RegBitsInUse:    cur_bits = v[5:0];
      RegChecksInUse:  cur_checks = v[4:0];
      RegLogicalInUse: cur_logical = v[2:0];
      default:         cur_weight = v[2:0];
    endcase
  endtask

  task automatic set_config(int b, int c, int l, int w);
    drain();
    write_reg(RegBitsInUse, b);
    write_reg(RegChecksInUse, c);
    write_reg(RegLogicalInUse, l);
    write_reg(RegMaxWeight, w);
  endtask

  // Syndrome formed from a random low-weight pattern over the bits in use.
  function automatic logic [15:0] reachable_syndrome(int unsigned nb, int unsigned w);
    logic [15:0] s;
    s = '0;
    for (int unsigned k = 0; k < $urandom_range(0, w); k++)
      s ^= col_mem[$urandom_range(0, nb - 1)][15:0];
    return s;
  endfunction

  // Loads of extreme values and full-range columns, then decodes at reset settings.
  task automatic test_directed_extremes();
    for (int i = 0; i < 32; i++) begin
      if (i == 0) send_beat(CmdLoad, 5'd0, 16'hFFFF, 4'hF, 16'hFFFF, 16'h0);
      else if (i == 1) send_beat(CmdLoad, 5'd1, 16'h0, 4'h0, 16'h0, 16'hFFFF);
      else load_col(i);
    end
    decode(16'h0);
    decode(16'hFFFF);
    decode(col_mem[0][15:0] ^ col_mem[5][15:0]);
    decode(col_mem[7][15:0]);
  endtask

  // Small settings: ties, zero-weight, empty-pattern only, all-ones register values.
  task automatic test_small_settings();
    set_config(4, 2, 2, 0);
    decode(16'h0);
    decode(16'h3);
    set_config(0, 3, 1, 4);
    decode(16'h0);
    set_config(3, 1, 2, 3);
    send_beat(CmdLoad, 5'd0, 16'h1, 4'h1, 16'h8000, 16'h0);
    send_beat(CmdLoad, 5'd1, 16'h1, 4'h2, 16'h8000, 16'h0);
    send_beat(CmdLoad, 5'd2, 16'h0, 4'h3, 16'h0, 16'h0);
    decode(16'h1);
    decode(16'h0);
    decode(16'hFFFE);
    set_config(63, 31, 7, 7);
    decode(16'h0);
    decode(reachable_syndrome(32, 4));
  endtask

  // Random settings with mostly reachable syndromes and fresh columns.
  task automatic test_random_decodes();
    int unsigned nb, w;
    for (int ph = 0; ph < 8; ph++) begin
      nb = (ph % 4 == 0) ? 32 : $urandom_range(1, 14);
      w = (nb > 20) ? $urandom_range(0, 3) : $urandom_range(0, 4);
      set_config(nb, $urandom_range(1, 16), $urandom_range(1, 4), w);
      for (int k = 0; k < 8; k++) begin
        if ($urandom_range(0, 2) == 0) load_col($urandom_range(0, 31));
        else if ($urandom_range(0, 3) == 0) decode(16'($urandom));
        else decode(reachable_syndrome(nb, w));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; command = CmdLoad; column_index = '0; column_checks = '0;
    column_logical = '0; bit_factor = '0; syndrome = '0;
    cur_bits = 6'd32; cur_checks = 5'd16; cur_logical = 3'd4; cur_weight = 3'd2;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_small_settings();
    test_random_decodes();
    drain();
    $display("Covered %0d decodes over directed extremes and random configurations.",
             decodes_checked);
    if (errors == 0 && expected_decisions.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
